// File: rtl/core/double_ended_queue_macros.svh
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// consequent checked in the same cycle
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/deq_pkg.sv
package deq_pkg;

  // sizes
  localparam int DEPTH       = 64;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ENTRY_W     = 7;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int GROUP_SIZE  = 8;
  localparam int GROUP_COUNT = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // operation that every cell of the row performs
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  word;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [WORD_W-1:0]  push_value;
  } request_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  pop_value;
    logic [STATUS_W-1:0]       status;
    logic [ENTRY_W-1:0]        entry_count;
  } result_t;

endpackage

// File: rtl/core/deq_cell.sv
module deq_cell (
  input  logic                                 clk,
  input  deq_pkg::cell_ctrl_t                  ctrl,
  input  logic signed [deq_pkg::WORD_W-1:0]    lower_word,
  input  logic signed [deq_pkg::WORD_W-1:0]    upper_word,
  input  logic                                 at_free,
  input  logic                                 at_tail,
  output logic signed [deq_pkg::WORD_W-1:0]    word,
  output logic signed [deq_pkg::WORD_W-1:0]    tail_word
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] word_next;

  // hold, shift toward the back, shift toward the front, or take the new word at the free slot
  always_comb begin
    unique case (ctrl.op)
      CELL_HOLD:       word_next = word;
      CELL_SHIFT_UP:   word_next = lower_word;
      CELL_SHIFT_DOWN: word_next = upper_word;
      CELL_APPEND:     word_next = at_free ? ctrl.word : word;
      default:         word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // only the last occupied cell offers its word to the gather tree
  assign tail_word = at_tail ? word : '0;

endmodule

// File: rtl/core/deq_gather.sv
module deq_gather (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [deq_pkg::WORD_W-1:0]    tail_word [deq_pkg::DEPTH],
  output logic signed [deq_pkg::WORD_W-1:0]    back_word
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] group_next [GROUP_COUNT];
  logic signed [WORD_W-1:0] group_q    [GROUP_COUNT];

  // first level: or of each group of cells
  for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_group
    always_comb begin
      group_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < DEPTH) begin
          group_next[g] = group_next[g] | tail_word[g * GROUP_SIZE + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        group_q[g] <= group_next[g];
      end
    end
  end

  // second level: or of the registered groups
  always_comb begin
    back_word = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      back_word = back_word | group_q[g];
    end
  end

endmodule

// File: rtl/core/double_ended_queue.sv
// Double-ended queue of up to 64 signed 32-bit words, held in a row of cells
// with the front word always in the first cell. Raise start with a request
// while busy is low; the item is taken at that edge and busy stays high for
// the next cycle, during which strobe marks the one result: the
// popped word (zero unless a pop succeeded), a status (done, empty on pop,
// full on push) and the entry count after the command. The back word is
// collected from the cell row by a registered or-tree, and no new item is
// taken while busy is high. Results cannot be held off: the receiver must
// take each one in the cycle that strobe is high. A pop from an empty
// queue and a push into a full one change nothing.
`include "double_ended_queue_macros.svh"

module double_ended_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::request_t  request,
  output logic               strobe,
  output deq_pkg::result_t   result
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_FRONT,
    SRC_BACK
  } pop_src_t;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     pending;
  logic [STATUS_W-1:0]      status_next;
  logic [STATUS_W-1:0]      status_q;
  pop_src_t                 src_next;
  pop_src_t                 src_q;
  logic signed [WORD_W-1:0] front_q;
  logic signed [WORD_W-1:0] back_word;
  cell_ctrl_t               ctrl;
  logic                     at_free   [DEPTH];
  logic                     at_tail   [DEPTH];
  logic signed [WORD_W-1:0] cell_word [DEPTH];
  logic signed [WORD_W-1:0] tail_word [DEPTH];

  assign accept = start & ~busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  // command decode and count update
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.word   = request.push_value;
    status_next = ST_DONE;
    count_next  = count;
    src_next    = SRC_NONE;
    if (accept) begin
      unique case (request.command)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_SHIFT_UP;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_APPEND;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.op    = CELL_SHIFT_DOWN;
            count_next = count - CNT_W'(1);
            src_next   = SRC_FRONT;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            count_next = count - CNT_W'(1);
            src_next   = SRC_BACK;
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  // decode of the first free cell and the last occupied cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      at_free[i] = (count == CNT_W'(i));
      at_tail[i] = (count == CNT_W'(i + 1));
    end
  end

  // row of cells, front word in cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] lower_word;
    logic signed [WORD_W-1:0] upper_word;

    if (i == 0) begin : g_first
      assign lower_word = ctrl.word;
    end else begin : g_inner_lo
      assign lower_word = cell_word[i - 1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_word = '0;
    end else begin : g_inner_hi
      assign upper_word = cell_word[i + 1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .at_free    (at_free[i]),
      .at_tail    (at_tail[i]),
      .word       (cell_word[i]),
      .tail_word  (tail_word[i])
    );
  end

  // back word collected over the cycle after accept
  deq_gather u_gather (
    .clk       (clk),
    .load      (accept),
    .tail_word (tail_word),
    .back_word (back_word)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
    end else begin
      pending <= accept;
      count   <= count_next;
    end
  end

  // result payload captured with the item
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      src_q    <= src_next;
      front_q  <= cell_word[0];
    end
  end

  assign busy   = pending;
  assign strobe = pending;

  // result select
  always_comb begin
    unique case (src_q)
      SRC_FRONT: result.pop_value = front_q;
      SRC_BACK:  result.pop_value = back_word;
      default:   result.pop_value = '0;
    endcase
    result.status      = status_q;
    result.entry_count = ENTRY_W'(count);
  end

  `DEQ_ASSERT_SAME(a_count_range, 1'b1, count <= CNT_W'(DEPTH), "count beyond depth")
  `DEQ_ASSERT_NEXT(a_result_follows, accept, strobe, "no result after accepted item")
  `DEQ_ASSERT_SAME(a_full_count, strobe && result.status == ST_FULL, count == CNT_W'(DEPTH), "full status with room left")
  `DEQ_ASSERT_NEXT(a_empty_pop, accept && request.command[1] && empty, strobe && result.status == ST_EMPTY && result.pop_value == '0, "empty pop result wrong")
  `DEQ_ASSERT_NEXT(a_push_count, accept && !request.command[1] && !full, count == CNT_W'($past(count) + CNT_W'(1)), "push did not grow count")

endmodule
